/* rtl/mwbs_pkg.sv */
// Shared definitions for the matrix window box sum block.
// Holds size defaults, the register index codes and the item flag bundle.
// No dependencies.
`timescale 1ns / 1ps

package mwbs_pkg;

   localparam int MAX_DIM_DEFAULT      = 64;
   localparam int ELEMENT_BITS_DEFAULT = 16;
   localparam int CFG_W                = 7;
   localparam int CSR_IDX_W            = 2;
   localparam int QUEUE_DEPTH          = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MATRIX_ROWS,
      CSR_MATRIX_COLS,
      CSR_WINDOW_ROWS,
      CSR_WINDOW_COLS
   } mwbs_csr_type;

   typedef struct packed {
      logic err;
      logic first_row;
      logic sub_line;
      logic first_col;
      logic sub_ck;
      logic emit;
      logic last;
   } mwbs_flags_type;

endpackage

/* rtl/mwbs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on mwbs_pkg for parameter defaults only.
`timescale 1ns / 1ps

module mwbs_ram #(
   parameter int WIDTH  = mwbs_pkg::ELEMENT_BITS_DEFAULT,
   parameter int DEPTH  = mwbs_pkg::MAX_DIM_DEFAULT,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mwbs_front.sv */
// Front end: size registers, raster position counters and item classification.
// Depends on mwbs_pkg for register codes and the flag bundle.
`timescale 1ns / 1ps

module mwbs_front #(
   parameter int MAX_DIM      = mwbs_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_BITS = mwbs_pkg::ELEMENT_BITS_DEFAULT,
   localparam int DIM_BITS    = $clog2(MAX_DIM)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [mwbs_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [mwbs_pkg::CFG_W-1:0]      csr_wdata,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic signed [ELEMENT_BITS-1:0]  in_data,
   input  logic                            q_ready,
   output logic                            push,
   output logic signed [ELEMENT_BITS-1:0]  item_x,
   output logic [DIM_BITS-1:0]             item_row,
   output logic [DIM_BITS-1:0]             item_col,
   output logic [DIM_BITS-1:0]             item_line_row,
   output logic [DIM_BITS-1:0]             item_ck_col,
   output mwbs_pkg::mwbs_flags_type        item_flags
);

   import mwbs_pkg::*;

   localparam int CMP_W = (DIM_BITS + 1 > CFG_W) ? DIM_BITS + 1 : CFG_W;

   logic [CFG_W-1:0]    m_ff, n_ff, p_ff, k_ff;
   logic [CFG_W-1:0]    m_in, n_in, p_in, k_in;
   logic [DIM_BITS-1:0] row_ff, col_ff, row_in, col_in;
   logic                restart;
   logic                cfg_ok;
   logic [CMP_W-1:0]    m_x, n_x, p_x, k_x, lim_x;
   logic [CMP_W-1:0]    row_x, col_x, row1_x, col1_x, line_row_x, ck_col_x;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff   <= CFG_W'(1);
         n_ff   <= CFG_W'(1);
         p_ff   <= CFG_W'(1);
         k_ff   <= CFG_W'(1);
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         m_ff   <= m_in;
         n_ff   <= n_in;
         p_ff   <= p_in;
         k_ff   <= k_in;
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   always_comb begin
      m_x        = CMP_W'(m_ff);
      n_x        = CMP_W'(n_ff);
      p_x        = CMP_W'(p_ff);
      k_x        = CMP_W'(k_ff);
      lim_x      = CMP_W'(MAX_DIM);
      row_x      = CMP_W'(row_ff);
      col_x      = CMP_W'(col_ff);
      row1_x     = row_x + CMP_W'(1);
      col1_x     = col_x + CMP_W'(1);
      line_row_x = row_x - p_x;
      ck_col_x   = col_x - k_x;
      cfg_ok     = (m_x != '0) && (n_x != '0) && (p_x != '0) && (k_x != '0) &&
                   (m_x <= lim_x) && (n_x <= lim_x) && (p_x <= m_x) && (k_x <= n_x);
   end

   assign in_ready = q_ready;
   assign push     = in_valid && q_ready;

   always_comb begin
      m_in    = m_ff;
      n_in    = n_ff;
      p_in    = p_ff;
      k_in    = k_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      restart = 1'b0;
      if (csr_we) begin
         restart = 1'b1;
         unique case (mwbs_csr_type'(csr_addr))
            CSR_MATRIX_ROWS: m_in = csr_wdata;
            CSR_MATRIX_COLS: n_in = csr_wdata;
            CSR_WINDOW_ROWS: p_in = csr_wdata;
            CSR_WINDOW_COLS: k_in = csr_wdata;
         endcase
      end
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (push && cfg_ok) begin
         if (col1_x >= n_x) begin
            col_in = '0;
            row_in = (row1_x >= m_x) ? '0 : row1_x[DIM_BITS-1:0];
         end else begin
            col_in = col1_x[DIM_BITS-1:0];
         end
      end
   end

   always_comb begin
      item_x               = in_data;
      item_row             = row_ff;
      item_col             = col_ff;
      item_line_row        = line_row_x[DIM_BITS-1:0];
      item_ck_col          = ck_col_x[DIM_BITS-1:0];
      item_flags.err       = !cfg_ok;
      item_flags.first_row = cfg_ok && (row_x == '0);
      item_flags.sub_line  = cfg_ok && (row_x >= p_x);
      item_flags.first_col = cfg_ok && (col_x == '0);
      item_flags.sub_ck    = cfg_ok && (col_x >= k_x);
      item_flags.emit      = cfg_ok && (row1_x >= p_x) && (col1_x >= k_x);
      item_flags.last      = cfg_ok && (row1_x == m_x) && (col1_x == n_x);
   end

   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      cfg_ok |-> (row_x < m_x) && (col_x < n_x))
      else $error("raster position outside the configured matrix");

endmodule

/* rtl/mwbs_queue.sv */
// Short FIFO between the classifying front end and the arithmetic back end.
// Depends on mwbs_pkg for the default depth.
`timescale 1ns / 1ps

module mwbs_queue #(
   parameter int WIDTH  = mwbs_pkg::ELEMENT_BITS_DEFAULT,
   parameter int DEPTH  = mwbs_pkg::QUEUE_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign do_push   = in_valid && in_ready;
   assign do_pop    = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff == $past(count_ff) + CNT_W'(1)))
      else $error("queue fill count did not advance on a lone push");

endmodule

/* rtl/mwbs_back.sv */
// Back end: line store and column sum memories, running window sum, result register.
// Depends on mwbs_pkg and mwbs_ram.
`timescale 1ns / 1ps

module mwbs_back #(
   parameter int MAX_DIM      = mwbs_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_BITS = mwbs_pkg::ELEMENT_BITS_DEFAULT,
   localparam int DIM_BITS    = $clog2(MAX_DIM),
   localparam int SUM_W       = ELEMENT_BITS + 2 * DIM_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            q_valid,
   output logic                            q_pop,
   input  logic signed [ELEMENT_BITS-1:0]  q_x,
   input  logic [DIM_BITS-1:0]             q_row,
   input  logic [DIM_BITS-1:0]             q_col,
   input  logic [DIM_BITS-1:0]             q_line_row,
   input  logic [DIM_BITS-1:0]             q_ck_col,
   input  mwbs_pkg::mwbs_flags_type        q_flags,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [SUM_W-1:0]                rsp_sum,
   output logic                            rsp_last,
   output logic                            rsp_err
);

   import mwbs_pkg::*;

   localparam int CS_W       = ELEMENT_BITS + DIM_BITS;
   localparam int LINE_DEPTH = MAX_DIM << DIM_BITS;

   logic                           adv;
   logic                           line_we, cs_we;
   logic signed [ELEMENT_BITS-1:0] line_rd;
   logic signed [CS_W-1:0]         cs_rd, csk_rd;

   logic                           s2_valid_ff, s2_valid_in;
   logic signed [ELEMENT_BITS-1:0] s2_x_ff;
   logic [DIM_BITS-1:0]            s2_col_ff, s2_ck_ff;
   mwbs_flags_type                 s2_flags_ff;

   logic                           s3_valid_ff, s3_valid_in;
   logic [DIM_BITS-1:0]            s3_col_ff;
   logic signed [CS_W-1:0]         s3_cs_ff, s3_csk_ff;
   mwbs_flags_type                 s3_flags_ff;

   logic signed [CS_W-1:0]         x_cs, line_term, cs_old, csk, cs_new;
   logic signed [SUM_W-1:0]        wsum_ff, wsum_in, wsum_base, wsum_new;
   logic                           s3_fwd;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]               rsp_sum_ff;
   logic                           rsp_last_ff, rsp_err_ff;

   assign adv     = !rsp_valid_ff || rsp_ready;
   assign q_pop   = adv && q_valid;
   assign line_we = q_pop && !q_flags.err;
   assign cs_we   = adv && s2_valid_ff && !s2_flags_ff.err;

   mwbs_ram #(.WIDTH(ELEMENT_BITS), .DEPTH(LINE_DEPTH)) u_line_store (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr ({q_row, q_col}),
      .wr_data (q_x),
      .rd_en   (adv),
      .rd_addr ({q_line_row, q_col}),
      .rd_data (line_rd)
   );

   mwbs_ram #(.WIDTH(CS_W), .DEPTH(MAX_DIM)) u_col_sum (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (s2_col_ff),
      .wr_data (cs_new),
      .rd_en   (adv),
      .rd_addr (q_col),
      .rd_data (cs_rd)
   );

   mwbs_ram #(.WIDTH(CS_W), .DEPTH(MAX_DIM)) u_col_sum_lag (
      .clock   (clock),
      .wr_en   (cs_we),
      .wr_addr (s2_col_ff),
      .wr_data (cs_new),
      .rd_en   (adv),
      .rd_addr (q_ck_col),
      .rd_data (csk_rd)
   );

   // forward the column sum written in the same cycle as this item's read
   always_comb begin
      s3_fwd    = s3_valid_ff && !s3_flags_ff.err;
      x_cs      = CS_W'(s2_x_ff);
      line_term = s2_flags_ff.sub_line ? CS_W'(line_rd) : '0;
      cs_old    = (s3_fwd && (s3_col_ff == s2_col_ff)) ? s3_cs_ff : cs_rd;
      csk       = (s3_fwd && (s3_col_ff == s2_ck_ff)) ? s3_cs_ff : csk_rd;
      cs_new    = s2_flags_ff.first_row ? x_cs : cs_old + x_cs - line_term;
   end

   always_comb begin
      wsum_base = s3_flags_ff.first_col ? '0 : wsum_ff;
      wsum_new  = wsum_base + SUM_W'(s3_cs_ff)
                  - (s3_flags_ff.sub_ck ? SUM_W'(s3_csk_ff) : '0);
      wsum_in   = wsum_ff;
      if (adv && s3_fwd) begin
         wsum_in = (s3_flags_ff.emit && s3_flags_ff.last) ? '0 : wsum_new;
      end
      s2_valid_in  = adv ? q_valid : s2_valid_ff;
      s3_valid_in  = adv ? s2_valid_ff : s3_valid_ff;
      rsp_valid_in = adv ? (s3_valid_ff && (s3_flags_ff.err || s3_flags_ff.emit))
                         : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wsum_ff      <= '0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wsum_ff      <= wsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_x_ff     <= q_x;
         s2_col_ff   <= q_col;
         s2_ck_ff    <= q_ck_col;
         s2_flags_ff <= q_flags;
         s3_col_ff   <= s2_col_ff;
         s3_cs_ff    <= cs_new;
         s3_csk_ff   <= csk;
         s3_flags_ff <= s2_flags_ff;
         rsp_sum_ff  <= s3_flags_ff.err ? '0 : wsum_new;
         rsp_last_ff <= !s3_flags_ff.err && s3_flags_ff.last;
         rsp_err_ff  <= s3_flags_ff.err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sum   = rsp_sum_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_err   = rsp_err_ff;

   a_wsum_clear: assert property (@(posedge clock) disable iff (reset)
      (adv && s3_fwd && s3_flags_ff.emit && s3_flags_ff.last) |=> (wsum_ff == '0))
      else $error("running sum not cleared after the final window");

   a_err_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> ((rsp_sum_ff == '0) && !rsp_last_ff))
      else $error("error result carries a sum or a last mark");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(wsum_ff) && $stable(s3_valid_ff))
      else $error("back end state moved while the result was stalled");

endmodule

/* rtl/matrix_window_box_sum.sv */
// Each element passes the queue, two stages and the result register. Throughput: one
//   element per cycle while results are taken, set by one pass per element through the line
//   store and column sum memories, each with one write and a registered read per cycle.
// Reset (synchronous): sizes return to 1, the raster position to the origin, queue and
//   pipeline empty. Line store and column sums are not cleared: every entry is written
//   in a matrix pass before it is used, so no clearing pass is needed.
`timescale 1ns / 1ps

module matrix_window_box_sum #(
   parameter int MAX_DIM      = mwbs_pkg::MAX_DIM_DEFAULT,
   parameter int ELEMENT_BITS = mwbs_pkg::ELEMENT_BITS_DEFAULT,
   localparam int DIM_BITS    = $clog2(MAX_DIM),
   localparam int SUM_W       = ELEMENT_BITS + 2 * DIM_BITS,
   localparam int REQ_W       = ((ELEMENT_BITS + 7) / 8) * 8,
   localparam int RSP_W       = ((SUM_W + 7) / 8) * 8
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [mwbs_pkg::CSR_IDX_W-1:0] csr_addr,
   input  logic [mwbs_pkg::CFG_W-1:0]     csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [REQ_W-1:0]               req_tdata,   // element_value
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RSP_W-1:0]               rsp_tdata,   // window_sum
   output logic                           rsp_tlast,   // last_window
   output logic                           rsp_tuser    // config_error
);

   import mwbs_pkg::*;

   localparam int FLAG_W = $bits(mwbs_flags_type);
   localparam int QW     = ELEMENT_BITS + 4 * DIM_BITS + FLAG_W;

   logic                           push, q_ready, q_valid, q_pop;
   logic signed [ELEMENT_BITS-1:0] f_x, q_x;
   logic [DIM_BITS-1:0]            f_row, f_col, f_line_row, f_ck_col;
   logic [DIM_BITS-1:0]            q_row, q_col, q_line_row, q_ck_col;
   mwbs_flags_type                 f_flags, q_flags;
   logic [QW-1:0]                  q_in, q_out;
   logic [SUM_W-1:0]               rsp_sum;

   mwbs_front #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_data       (req_tdata[ELEMENT_BITS-1:0]),
      .q_ready       (q_ready),
      .push          (push),
      .item_x        (f_x),
      .item_row      (f_row),
      .item_col      (f_col),
      .item_line_row (f_line_row),
      .item_ck_col   (f_ck_col),
      .item_flags    (f_flags)
   );

   assign q_in = {f_flags, f_line_row, f_ck_col, f_row, f_col, f_x};

   mwbs_queue #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push),
      .in_ready  (q_ready),
      .in_data   (q_in),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_data  (q_out)
   );

   assign {q_flags, q_line_row, q_ck_col, q_row, q_col, q_x} = q_out;

   mwbs_back #(.MAX_DIM(MAX_DIM), .ELEMENT_BITS(ELEMENT_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_pop      (q_pop),
      .q_x        (q_x),
      .q_row      (q_row),
      .q_col      (q_col),
      .q_line_row (q_line_row),
      .q_ck_col   (q_ck_col),
      .q_flags    (q_flags),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_sum    (rsp_sum),
      .rsp_last   (rsp_tlast),
      .rsp_err    (rsp_tuser)
   );

   assign rsp_tdata = RSP_W'(rsp_sum);

endmodule
